// ===== rtl/dpg_pkg.sv =====
package dpg_pkg;

    typedef struct packed {
        logic signed [31:0] plane_a;
        logic signed [31:0] plane_b;
        logic signed [31:0] plane_c;
        logic        [30:0] plane_inv_norm;
        logic        [23:0] inv_focal_x;
        logic        [23:0] inv_focal_y;
        logic        [15:0] center_x;
        logic        [15:0] center_y;
    } dpg_cfg_t;

    typedef struct packed {
        logic               zero;
        logic signed [31:0] px;
        logic signed [31:0] pz;
    } dpg_point_t;

    typedef struct packed {
        logic               zero;
        logic        [1:0]  cls;
        logic signed [31:0] xx;
        logic signed [31:0] zz;
    } dpg_proj_t;

    localparam logic [2:0] REG_PLANE_A     = 3'd0;
    localparam logic [2:0] REG_PLANE_B     = 3'd1;
    localparam logic [2:0] REG_PLANE_C     = 3'd2;
    localparam logic [2:0] REG_PLANE_INV_N = 3'd3;
    localparam logic [2:0] REG_INV_FOCAL_X = 3'd4;
    localparam logic [2:0] REG_INV_FOCAL_Y = 3'd5;
    localparam logic [2:0] REG_CENTER_X    = 3'd6;
    localparam logic [2:0] REG_CENTER_Y    = 3'd7;

    localparam logic [1:0] CLS_NONE  = 2'd0;
    localparam logic [1:0] CLS_FLOOR = 2'd1;
    localparam logic [1:0] CLS_OBST  = 2'd2;

    localparam logic [7:0] VAL_FLOOR = 8'd255;
    localparam logic [7:0] VAL_OBST  = 8'd125;

    localparam logic [32:0] FLOOR_MAX_Q = 33'd5898;
    localparam logic [32:0] OBST_MIN_Q  = 33'd6554;
    localparam logic [32:0] OBST_MAX_Q  = 33'd117965;
    localparam logic [64:0] RANGE_SQ_Q  = 65'd429496729600;
    localparam logic signed [31:0] HALF_SPAN_Q = 32'sd1310720;

    localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
    localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > SAT_MAX)
            r = 32'sh7FFF_FFFF;
        else if (v < SAT_MIN)
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

// ===== rtl/dpg_point.sv =====
module dpg_point (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  dpg_pkg::dpg_cfg_t   cfg,
    input  logic                in_vld,
    input  logic [15:0]         depth,
    input  logic [11:0]         pixel_col,
    input  logic [11:0]         pixel_row,
    output logic                pt_vld,
    output dpg_pkg::dpg_point_t pt,
    output logic signed [31:0]  py
);

    // reciprocal of 625: pz uses 2^39 scale, px/py use 2^41 scale
    localparam logic [29:0] MZ       = 30'd879609302;
    localparam logic [31:0] MX       = 32'd3518437208;
    localparam logic [59:0] HALF_DIV = 60'd10240000;
    localparam logic [59:0] BIG_T    = 60'd1342177280000;

    logic [6:1] vld_reg;
    logic [6:1] zero_reg;
    logic signed [31:0] lane_p [2];

    logic [28:0] nz1_reg;
    logic [28:0] nz2_reg;
    logic [58:0] zp2_reg;
    logic [19:0] pz3_reg, pz4_reg, pz5_reg, pz6_reg;

    logic [19:0] qz;
    logic [28:0] rz;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[5:1], in_vld};
        end
    end

    assign qz = zp2_reg[58:39];
    assign rz = nz2_reg - 29'(qz) * 29'd625;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            zero_reg <= {zero_reg[5:1], (depth == 16'd0)};
            nz1_reg  <= {depth, 13'd0} + 29'd312;
            nz2_reg  <= nz1_reg;
            zp2_reg  <= 59'(nz1_reg) * 59'(MZ);
            pz3_reg  <= qz + 20'(rz >= 29'd625);
            pz4_reg  <= pz3_reg;
            pz5_reg  <= pz4_reg;
            pz6_reg  <= pz5_reg;
        end
    end

    for (genvar l = 0; l < 2; l++)
    begin : g_lane
        logic        [23:0] inv_f;
        logic        [15:0] ctr;
        logic        [11:0] coord;
        logic signed [17:0] dc;
        logic        [59:0] mag;
        logic        [59:0] t_full;
        logic        [72:0] full;
        logic        [40:0] r6;
        logic        [31:0] q6;

        logic signed [34:0] pr1_reg;
        logic signed [59:0] m2_reg;
        logic        [40:0] t3_reg, t4_reg, t5_reg;
        logic               big3_reg, big4_reg, big5_reg;
        logic               sg3_reg, sg4_reg, sg5_reg;
        logic        [52:0] lo4_reg;
        logic        [51:0] hi4_reg;
        logic        [31:0] qe5_reg;
        logic signed [31:0] p6_reg;

        assign inv_f = (l == 0) ? cfg.inv_focal_x : cfg.inv_focal_y;
        assign ctr   = (l == 0) ? cfg.center_x : cfg.center_y;
        assign coord = (l == 0) ? pixel_col : pixel_row;
        assign dc    = $signed({2'b00, coord, 4'b0000}) - $signed({2'b00, ctr});

        assign mag    = m2_reg[59] ? 60'(-m2_reg) : 60'(m2_reg);
        assign t_full = (mag + HALF_DIV) >> 15;
        assign full   = {hi4_reg, 21'd0} + 73'(lo4_reg);
        assign r6     = t5_reg - 41'(qe5_reg) * 41'd625;
        assign q6     = qe5_reg + 32'(r6 >= 41'd625);

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                pr1_reg  <= $signed({1'b0, depth}) * dc;
                m2_reg   <= pr1_reg * $signed({1'b0, inv_f});
                t3_reg   <= t_full[40:0];
                big3_reg <= (t_full >= BIG_T);
                sg3_reg  <= m2_reg[59];
                lo4_reg  <= 53'(t3_reg[20:0]) * 53'(MX);
                hi4_reg  <= 52'(t3_reg[40:21]) * 52'(MX);
                t4_reg   <= t3_reg;
                big4_reg <= big3_reg;
                sg4_reg  <= sg3_reg;
                qe5_reg  <= full[72:41];
                t5_reg   <= t4_reg;
                big5_reg <= big4_reg;
                sg5_reg  <= sg4_reg;
                // saturate once the quotient reaches 2^31
                if (big5_reg)
                    p6_reg <= sg5_reg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                else
                    p6_reg <= sg5_reg ? (32'd0 - q6) : q6;
            end
        end

        assign lane_p[l] = p6_reg;
    end

    assign pt_vld  = vld_reg[6];
    assign pt.zero = zero_reg[6];
    assign pt.px   = lane_p[0];
    assign pt.pz   = $signed({12'd0, pz6_reg});

    // py only feeds the plane distance; hand it over beside the point
    assign py = lane_p[1];

endmodule

// ===== rtl/dpg_plane.sv =====
module dpg_plane (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  dpg_pkg::dpg_cfg_t   cfg,
    input  logic                pt_vld,
    input  dpg_pkg::dpg_point_t pt,
    input  logic signed [31:0]  py,
    output logic                pj_vld,
    output dpg_pkg::dpg_proj_t  pj
);

    logic [14:7] vld_reg;
    dpg_pkg::dpg_point_t cy_reg [7:13];

    logic signed [63:0] pa7_reg, pb7_reg, pc7_reg;
    logic signed [31:0] dot8_reg;
    logic signed [63:0] dn9_reg;
    logic signed [31:0] dist10_reg;
    logic signed [63:0] kn11_reg;
    logic        [1:0]  cls11_reg, cls12_reg, cls13_reg;
    logic signed [31:0] k12_reg;
    logic signed [63:0] ak13_reg, ck13_reg;
    dpg_pkg::dpg_proj_t pj14_reg;

    logic signed [63:0] inv_n;
    logic        [32:0] adist;
    logic        [1:0]  cls;

    assign inv_n = 64'($signed({1'b0, cfg.plane_inv_norm}));
    assign adist = dist10_reg[31] ? (33'd0 - {dist10_reg[31], dist10_reg})
                                  : {1'b0, dist10_reg};

    always_comb
    begin
        if (adist < dpg_pkg::FLOOR_MAX_Q)
            cls = dpg_pkg::CLS_FLOOR;
        else if (adist > dpg_pkg::OBST_MIN_Q && adist < dpg_pkg::OBST_MAX_Q)
            cls = dpg_pkg::CLS_OBST;
        else
            cls = dpg_pkg::CLS_NONE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[13:7], pt_vld};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cy_reg[7] <= pt;
            for (int s = 8; s <= 13; s++)
                cy_reg[s] <= cy_reg[s-1];

            pa7_reg    <= 64'(cfg.plane_a) * 64'(pt.px);
            pb7_reg    <= 64'(cfg.plane_b) * 64'(py);
            pc7_reg    <= 64'(cfg.plane_c) * 64'(pt.pz);
            dot8_reg   <= dpg_pkg::sat32((pa7_reg >>> 24) + (pb7_reg >>> 24)
                                         + (pc7_reg >>> 24) + 64'sd65536);
            dn9_reg    <= 64'(dot8_reg) * inv_n;
            dist10_reg <= dpg_pkg::sat32(dn9_reg >>> 24);
            kn11_reg   <= 64'(dist10_reg) * inv_n;
            cls11_reg  <= cls;
            k12_reg    <= dpg_pkg::sat32(kn11_reg >>> 24);
            cls12_reg  <= cls11_reg;
            ak13_reg   <= 64'(cfg.plane_a) * 64'(k12_reg);
            ck13_reg   <= 64'(cfg.plane_c) * 64'(k12_reg);
            cls13_reg  <= cls12_reg;
            pj14_reg.zero <= cy_reg[13].zero;
            pj14_reg.cls  <= cls13_reg;
            pj14_reg.xx   <= dpg_pkg::sat32(64'(cy_reg[13].px) - (ak13_reg >>> 24));
            pj14_reg.zz   <= dpg_pkg::sat32(64'(cy_reg[13].pz) - (ck13_reg >>> 24));
        end
    end

    assign pj_vld = vld_reg[14];
    assign pj     = pj14_reg;

endmodule

// ===== rtl/dpg_grid.sv =====
module dpg_grid #(
    parameter int GRID_SIZE = 1024
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  logic               pj_vld,
    input  dpg_pkg::dpg_proj_t pj,
    output logic               out_valid,
    output logic               mark_valid,
    output logic [1:0]         surface_class,
    output logic [9:0]         cell_row,
    output logic [9:0]         cell_col,
    output logic [7:0]         cell_value
);

    localparam int GW = $clog2(GRID_SIZE + 1);
    localparam int PW = 22 + GW;
    localparam int VW = PW - 19;
    localparam int MW = VW + 15;
    localparam int QW = MW - 17;
    localparam logic [14:0] M5 = 15'd26214;

    logic [17:15] vld_reg;

    logic [63:0] sqx15_reg, sqz15_reg;
    logic        in15_reg, zero15_reg;
    logic [1:0]  cls15_reg, cls16_reg;
    logic [21:0] ux15_reg, uz15_reg;
    logic        keep16_reg;
    logic [VW-1:0] vx16_reg, vz16_reg;

    logic        mv17_reg;
    logic [1:0]  cls17_reg;
    logic [9:0]  row17_reg, col17_reg;
    logic [7:0]  val17_reg;

    logic        in_grid;
    logic        keep;
    logic [PW-1:0] prx, prz;
    logic [MW-1:0] mx, mz;
    logic [QW-1:0] qx, qz;
    logic [VW-1:0] rx, rz;
    logic [QW-1:0] cx, cz;

    assign in_grid = (pj.xx > -dpg_pkg::HALF_SPAN_Q) && (pj.xx < dpg_pkg::HALF_SPAN_Q)
                  && (pj.zz > -dpg_pkg::HALF_SPAN_Q) && (pj.zz < dpg_pkg::HALF_SPAN_Q);

    assign keep = !zero15_reg && (cls15_reg != dpg_pkg::CLS_NONE) && in15_reg
               && (65'(sqx15_reg) + 65'(sqz15_reg) < dpg_pkg::RANGE_SQ_Q)
               && ((65'(sqx15_reg) << 1) + 65'(sqx15_reg) < 65'(sqz15_reg));

    assign prx = PW'(ux15_reg) * PW'(GRID_SIZE);
    assign prz = PW'(uz15_reg) * PW'(GRID_SIZE);

    // divide by five: reciprocal estimate, then one correction step
    assign mx = MW'(vx16_reg) * MW'(M5);
    assign mz = MW'(vz16_reg) * MW'(M5);
    assign qx = mx[MW-1:17];
    assign qz = mz[MW-1:17];
    assign rx = vx16_reg - VW'(qx) * VW'(5);
    assign rz = vz16_reg - VW'(qz) * VW'(5);
    assign cx = qx + QW'(rx >= VW'(5));
    assign cz = qz + QW'(rz >= VW'(5));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[16:15], pj_vld};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sqx15_reg  <= 64'(pj.xx) * 64'(pj.xx);
            sqz15_reg  <= 64'(pj.zz) * 64'(pj.zz);
            in15_reg   <= in_grid;
            zero15_reg <= pj.zero;
            cls15_reg  <= pj.cls;
            ux15_reg   <= 22'(pj.xx + dpg_pkg::HALF_SPAN_Q);
            uz15_reg   <= 22'(pj.zz + dpg_pkg::HALF_SPAN_Q);

            keep16_reg <= keep;
            cls16_reg  <= cls15_reg;
            vx16_reg   <= prx[PW-1:19];
            vz16_reg   <= prz[PW-1:19];

            // drop everything for a point that is not kept
            mv17_reg  <= keep16_reg;
            cls17_reg <= keep16_reg ? cls16_reg : dpg_pkg::CLS_NONE;
            row17_reg <= keep16_reg ? 10'(cx) : 10'd0;
            col17_reg <= keep16_reg ? 10'(cz) : 10'd0;
            if (!keep16_reg)
                val17_reg <= 8'd0;
            else if (cls16_reg == dpg_pkg::CLS_FLOOR)
                val17_reg <= dpg_pkg::VAL_FLOOR;
            else
                val17_reg <= dpg_pkg::VAL_OBST;
        end
    end

    assign out_valid     = vld_reg[17];
    assign mark_valid    = mv17_reg;
    assign surface_class = cls17_reg;
    assign cell_row      = row17_reg;
    assign cell_col      = col17_reg;
    assign cell_value    = val17_reg;

endmodule

// ===== rtl/depth_pixel_to_floor_grid_mark.sv =====
// Throughput: one item per cycle; all seventeen stages advance together and
// freeze only while a result is held by out_stall.
// Every pixel yields exactly one result item.
// Reset (rst_n low, asynchronous) empties the pipeline and loads the camera
// and ground plane registers with their defaults; no clearing pass.
module depth_pixel_to_floor_grid_mark #(
    parameter int GRID_SIZE = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] depth,
    input  logic [11:0] pixel_col,
    input  logic [11:0] pixel_row,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        mark_valid,
    output logic [1:0]  surface_class,
    output logic [9:0]  cell_row,
    output logic [9:0]  cell_col,
    output logic [7:0]  cell_value
);

    dpg_pkg::dpg_cfg_t   cfg_reg;
    dpg_pkg::dpg_point_t pt;
    dpg_pkg::dpg_proj_t  pj;
    logic                pt_vld;
    logic                pj_vld;
    logic                adv;
    logic signed [31:0]  py;
    logic [2:0]          ridx;

    assign adv      = ~(out_valid & out_stall);
    assign in_stall = ~adv;
    assign pready   = 1'b1;
    assign ridx     = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.plane_a        <= 32'sd390533;
            cfg_reg.plane_b        <= -32'sd9367472;
            cfg_reg.plane_c        <= -32'sd6628024;
            cfg_reg.plane_inv_norm <= 31'd24514696;
            cfg_reg.inv_focal_x    <= 24'd35780;
            cfg_reg.inv_focal_y    <= 24'd35780;
            cfg_reg.center_x       <= 16'd5185;
            cfg_reg.center_y       <= 16'd3782;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (ridx)
                dpg_pkg::REG_PLANE_A:     cfg_reg.plane_a        <= pwdata;
                dpg_pkg::REG_PLANE_B:     cfg_reg.plane_b        <= pwdata;
                dpg_pkg::REG_PLANE_C:     cfg_reg.plane_c        <= pwdata;
                dpg_pkg::REG_PLANE_INV_N: cfg_reg.plane_inv_norm <= pwdata[30:0];
                dpg_pkg::REG_INV_FOCAL_X: cfg_reg.inv_focal_x    <= pwdata[23:0];
                dpg_pkg::REG_INV_FOCAL_Y: cfg_reg.inv_focal_y    <= pwdata[23:0];
                dpg_pkg::REG_CENTER_X:    cfg_reg.center_x       <= pwdata[15:0];
                dpg_pkg::REG_CENTER_Y:    cfg_reg.center_y       <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (ridx)
            dpg_pkg::REG_PLANE_A:     prdata = cfg_reg.plane_a;
            dpg_pkg::REG_PLANE_B:     prdata = cfg_reg.plane_b;
            dpg_pkg::REG_PLANE_C:     prdata = cfg_reg.plane_c;
            dpg_pkg::REG_PLANE_INV_N: prdata = {1'b0, cfg_reg.plane_inv_norm};
            dpg_pkg::REG_INV_FOCAL_X: prdata = {8'd0, cfg_reg.inv_focal_x};
            dpg_pkg::REG_INV_FOCAL_Y: prdata = {8'd0, cfg_reg.inv_focal_y};
            dpg_pkg::REG_CENTER_X:    prdata = {16'd0, cfg_reg.center_x};
            dpg_pkg::REG_CENTER_Y:    prdata = {16'd0, cfg_reg.center_y};
            default:                  prdata = 32'd0;
        endcase
    end

    dpg_point u_point (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .cfg       (cfg_reg),
        .in_vld    (in_valid),
        .depth     (depth),
        .pixel_col (pixel_col),
        .pixel_row (pixel_row),
        .pt_vld    (pt_vld),
        .pt        (pt),
        .py        (py)
    );

    dpg_plane u_plane (
        .clk    (clk),
        .rst_n  (rst_n),
        .adv    (adv),
        .cfg    (cfg_reg),
        .pt_vld (pt_vld),
        .pt     (pt),
        .py     (py),
        .pj_vld (pj_vld),
        .pj     (pj)
    );

    dpg_grid #(
        .GRID_SIZE (GRID_SIZE)
    ) u_grid (
        .clk           (clk),
        .rst_n         (rst_n),
        .adv           (adv),
        .pj_vld        (pj_vld),
        .pj            (pj),
        .out_valid     (out_valid),
        .mark_valid    (mark_valid),
        .surface_class (surface_class),
        .cell_row      (cell_row),
        .cell_col      (cell_col),
        .cell_value    (cell_value)
    );

endmodule

// ===== rtl/dpg_checker.sv =====
module dpg_sva_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic       mark_valid,
    input logic [1:0] surface_class,
    input logic [9:0] cell_row,
    input logic [9:0] cell_col,
    input logic [7:0] cell_value
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(cell_row) && $stable(cell_col)
                                   && $stable(cell_value) && $stable(mark_valid))
        else $error("held result changed");

    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall == (out_valid && out_stall))
        else $error("input stall does not follow output hold");

    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !mark_valid |-> surface_class == dpg_pkg::CLS_NONE
            && cell_row == 10'd0 && cell_col == 10'd0 && cell_value == 8'd0)
        else $error("unmarked result carries data");

    a_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && mark_valid |->
            (surface_class == dpg_pkg::CLS_FLOOR && cell_value == dpg_pkg::VAL_FLOOR) ||
            (surface_class == dpg_pkg::CLS_OBST && cell_value == dpg_pkg::VAL_OBST))
        else $error("class and cell value disagree");

endmodule

bind depth_pixel_to_floor_grid_mark dpg_sva_checker u_dpg_checker (.*);

// ===== dv/dpg_checker.sv =====
module dpg_checker #(
    parameter int GRID_SIZE = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [15:0] depth,
    input  logic [11:0] pixel_col,
    input  logic [11:0] pixel_row,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic        mark_valid,
    input  logic [1:0]  surface_class,
    input  logic [9:0]  cell_row,
    input  logic [9:0]  cell_col,
    input  logic [7:0]  cell_value,
    output int          errors,
    output int          pending,
    output int          marks_seen,
    output int          items_seen
);

    typedef struct packed {
        logic       mark;
        logic [1:0] cls;
        logic [9:0] row;
        logic [9:0] col;
        logic [7:0] value;
    } grid_mark_t;

    dpg_pkg::dpg_cfg_t cam;
    grid_mark_t mark_queue[$];

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // floor division by 2^24
    function automatic longint shr24(longint v);
        return v >>> 24;
    endfunction

    function automatic longint round_div(longint n, longint d);
        longint m;
        longint q;
        m = (n < 0) ? -n : n;
        q = (m + d / 2) / d;
        return (n < 0) ? -q : q;
    endfunction

    function automatic logic [9:0] grid_index(longint v);
        longint u;
        u = (v + 1310720) * GRID_SIZE / 2621440;
        return u[9:0];
    endfunction

    function automatic grid_mark_t project_pixel(logic [15:0] d, logic [11:0] c,
                                                 logic [11:0] r);
        grid_mark_t m;
        longint a, b, cc, inv_n, dcol, drow, px, py, pz, dot, pdist, k, xx, zz, ad;
        longint sx, sz;
        logic [1:0] cls;
        m = '0;
        cls = dpg_pkg::CLS_NONE;
        if (d == 0)
            return m;
        a = cam.plane_a;
        b = cam.plane_b;
        cc = cam.plane_c;
        inv_n = {33'd0, cam.plane_inv_norm};
        dcol = longint'(c) * 16 - longint'(cam.center_x);
        drow = longint'(r) * 16 - longint'(cam.center_y);
        pz = clamp32(round_div(longint'(d) * 65536, 5000));
        px = clamp32(round_div(longint'(d) * dcol * longint'(cam.inv_focal_x), 20480000));
        py = clamp32(round_div(longint'(d) * drow * longint'(cam.inv_focal_y), 20480000));
        dot = clamp32(shr24(a * px) + shr24(b * py) + shr24(cc * pz) + 65536);
        pdist = clamp32(shr24(dot * inv_n));
        k = clamp32(shr24(pdist * inv_n));
        xx = clamp32(px - shr24(a * k));
        zz = clamp32(pz - shr24(cc * k));
        ad = pdist < 0 ? -pdist : pdist;
        if (ad < 5898)
            cls = dpg_pkg::CLS_FLOOR;
        else if (ad > 6554 && ad < 117965)
            cls = dpg_pkg::CLS_OBST;
        if (cls == dpg_pkg::CLS_NONE)
            return m;
        sx = xx * xx;
        sz = zz * zz;
        if (sx + sz < 64'sd429496729600 && 3 * sx < sz && xx > -1310720 && xx < 1310720
            && zz > -1310720 && zz < 1310720)
        begin
            m.mark = 1'b1;
            m.cls = cls;
            m.row = grid_index(xx);
            m.col = grid_index(zz);
            m.value = (cls == dpg_pkg::CLS_FLOOR) ? dpg_pkg::VAL_FLOOR : dpg_pkg::VAL_OBST;
        end
        return m;
    endfunction

    task automatic report(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        grid_mark_t e;
        if (!rst_n)
        begin
            cam.plane_a <= 32'sd390533;
            cam.plane_b <= -32'sd9367472;
            cam.plane_c <= -32'sd6628024;
            cam.plane_inv_norm <= 31'd24514696;
            cam.inv_focal_x <= 24'd35780;
            cam.inv_focal_y <= 24'd35780;
            cam.center_x <= 16'd5185;
            cam.center_y <= 16'd3782;
            mark_queue.delete();
            errors <= 0;
            pending <= 0;
            marks_seen <= 0;
            items_seen <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[4:2])
                    dpg_pkg::REG_PLANE_A: cam.plane_a <= pwdata;
                    dpg_pkg::REG_PLANE_B: cam.plane_b <= pwdata;
                    dpg_pkg::REG_PLANE_C: cam.plane_c <= pwdata;
                    dpg_pkg::REG_PLANE_INV_N: cam.plane_inv_norm <= pwdata[30:0];
                    dpg_pkg::REG_INV_FOCAL_X: cam.inv_focal_x <= pwdata[23:0];
                    dpg_pkg::REG_INV_FOCAL_Y: cam.inv_focal_y <= pwdata[23:0];
                    dpg_pkg::REG_CENTER_X: cam.center_x <= pwdata[15:0];
                    dpg_pkg::REG_CENTER_Y: cam.center_y <= pwdata[15:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                mark_queue.push_back(project_pixel(depth, pixel_col, pixel_row));
                items_seen <= items_seen + 1;
            end
            if (out_valid && !out_stall)
            begin
                if (mark_queue.size() == 0)
                begin
                    $display("unexpected result at %0t", $time);
                    errors++;
                end
                else
                begin
                    e = mark_queue.pop_front();
                    if (mark_valid !== e.mark)
                        report("mark_valid", mark_valid, e.mark);
                    if (surface_class !== e.cls)
                        report("surface_class", surface_class, e.cls);
                    if (cell_row !== e.row)
                        report("cell_row", cell_row, e.row);
                    if (cell_col !== e.col)
                        report("cell_col", cell_col, e.col);
                    if (cell_value !== e.value)
                        report("cell_value", cell_value, e.value);
                    if (e.mark)
                        marks_seen <= marks_seen + 1;
                end
            end
            pending <= mark_queue.size();
        end
    end

endmodule

// ===== dv/tb_depth_pixel_to_floor_grid_mark.sv =====
module tb_depth_pixel_to_floor_grid_mark;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_stall;
    logic [15:0] depth;
    logic [11:0] pixel_col;
    logic [11:0] pixel_row;
    logic        out_valid;
    logic        out_stall;
    logic        mark_valid;
    logic [1:0]  surface_class;
    logic [9:0]  cell_row;
    logic [9:0]  cell_col;
    logic [7:0]  cell_value;
    int          errors;
    int          pending;
    int          marks_seen;
    int          items_seen;
    int          idle_cycles;
    int          sent;
    bit          timed_out;
    bit          sink_gaps;

    depth_pixel_to_floor_grid_mark i_dut (.*);

    dpg_checker i_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // watchdog: cycles with no accepted item on either channel and no register access
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000)
        begin
            timed_out = 1'b1;
            $display("timeout: no progress");
            $display("== FAIL ==");
            $finish;
        end
    end

    // receiver: random stall length per item while sink_gaps is set
    initial
    begin
        int hold;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            hold = sink_gaps ? $urandom_range(0, 13) : 0;
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] v);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_pixel(logic [15:0] d, logic [11:0] c, logic [11:0] r, bit gaps);
        int gap;
        gap = gaps ? $urandom_range(0, 13) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        depth <= d;
        pixel_col <= c;
        pixel_row <= r;
        do
            @(posedge clk);
        while (in_stall);
        sent++;
    endtask

    task automatic drain();
        while (pending != 0 || in_valid)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        repeat (20) @(posedge clk);
    endtask

    task automatic load_camera(int setting);
        case (setting)
            0:
            begin
                write_reg(dpg_pkg::REG_PLANE_A, 32'd390533);
                write_reg(dpg_pkg::REG_PLANE_B, -32'sd9367472);
                write_reg(dpg_pkg::REG_PLANE_C, -32'sd6628024);
                write_reg(dpg_pkg::REG_PLANE_INV_N, 32'd24514696);
                write_reg(dpg_pkg::REG_INV_FOCAL_X, 32'd35780);
                write_reg(dpg_pkg::REG_INV_FOCAL_Y, 32'd35780);
                write_reg(dpg_pkg::REG_CENTER_X, 32'd5185);
                write_reg(dpg_pkg::REG_CENTER_Y, 32'd3782);
            end
            1:
            begin
                write_reg(dpg_pkg::REG_PLANE_A, 32'h7FFF_FFFF);
                write_reg(dpg_pkg::REG_PLANE_B, 32'h8000_0000);
                write_reg(dpg_pkg::REG_PLANE_C, 32'h7FFF_FFFF);
                write_reg(dpg_pkg::REG_PLANE_INV_N, 32'hFFFF_FFFF);
                write_reg(dpg_pkg::REG_INV_FOCAL_X, 32'hFFFF_FFFF);
                write_reg(dpg_pkg::REG_INV_FOCAL_Y, 32'hFF_FFFF);
                write_reg(dpg_pkg::REG_CENTER_X, 32'hFFFF);
                write_reg(dpg_pkg::REG_CENTER_Y, 32'hFFFF);
            end
            2:
            begin
                write_reg(dpg_pkg::REG_PLANE_A, 32'd0);
                write_reg(dpg_pkg::REG_PLANE_B, 32'd0);
                write_reg(dpg_pkg::REG_PLANE_C, 32'd0);
                write_reg(dpg_pkg::REG_PLANE_INV_N, 32'd0);
                write_reg(dpg_pkg::REG_INV_FOCAL_X, 32'd0);
                write_reg(dpg_pkg::REG_INV_FOCAL_Y, 32'd0);
                write_reg(dpg_pkg::REG_CENTER_X, 32'd0);
                write_reg(dpg_pkg::REG_CENTER_Y, 32'd0);
            end
            default:
            begin
                // near-level floor about 0.6..2.0 m below camera, random nearby intrinsics
                write_reg(dpg_pkg::REG_PLANE_A, $urandom_range(0, 800000) - 400000);
                write_reg(dpg_pkg::REG_PLANE_B, -$urandom_range(8000000, 30000000));
                write_reg(dpg_pkg::REG_PLANE_C, $urandom_range(0, 4000000) - 2000000);
                write_reg(dpg_pkg::REG_PLANE_INV_N, $urandom_range(10000000, 34000000));
                write_reg(dpg_pkg::REG_INV_FOCAL_X, $urandom_range(20000, 60000));
                write_reg(dpg_pkg::REG_INV_FOCAL_Y, $urandom_range(20000, 60000));
                write_reg(dpg_pkg::REG_CENTER_X, $urandom_range(3000, 8000));
                write_reg(dpg_pkg::REG_CENTER_Y, $urandom_range(2000, 6000));
            end
        endcase
    endtask

    initial
    begin
        int phase;
        logic [15:0] d;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        depth = '0;
        pixel_col = '0;
        pixel_row = '0;
        sent = 0;
        timed_out = 1'b0;
        sink_gaps = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: zero depth, field extremes, near-floor samples
        send_pixel(16'd0, 12'd320, 12'd240, 1'b0);
        send_pixel(16'hFFFF, 12'hFFF, 12'hFFF, 1'b0);
        send_pixel(16'd1, 12'd0, 12'd0, 1'b0);
        send_pixel(16'hFFFF, 12'd0, 12'hFFF, 1'b0);
        send_pixel(16'd5000, 12'd324, 12'd236, 1'b0);
        send_pixel(16'd10000, 12'd324, 12'd400, 1'b0);
        send_pixel(16'd15000, 12'd340, 12'd420, 1'b0);
        send_pixel(16'd49999, 12'd324, 12'd300, 1'b0);
        send_pixel(16'd50001, 12'd324, 12'd300, 1'b0);
        for (int r = 240; r < 480; r += 24)
            send_pixel(16'd8000, 12'd330, r[11:0], 1'b0);
        drain();
        // rewrite the principal row with its default
        write_reg(dpg_pkg::REG_CENTER_Y, 32'd3782);
        for (int s = 1; s < 3; s++)
        begin
            load_camera(s);
            send_pixel(16'hFFFF, 12'hFFF, 12'hFFF, 1'b0);
            send_pixel(16'd7000, 12'd0, 12'd0, 1'b0);
            send_pixel(16'd3000, 12'd500, 12'd700, 1'b0);
            drain();
        end

        sink_gaps = 1'b1;
        for (phase = 0; phase < 8; phase++)
        begin
            load_camera(phase == 0 ? 0 : 3);
            for (int i = 0; i < 150; i++)
            begin
                if ($urandom_range(0, 9) == 0)
                    d = 16'($urandom);
                else
                    d = 16'($urandom_range(1000, 40000));
                if ($urandom_range(0, 5) == 0)
                    send_pixel(d, 12'($urandom), 12'($urandom), 1'b1);
                else
                    send_pixel(d, 12'($urandom_range(250, 400)),
                               12'($urandom_range(230, 479)), i % 50 < 35);
            end
            drain();
        end

        $display("covered %0d pixels over 11 camera settings, %0d grid marks checked",
                 items_seen, marks_seen);
        if (errors == 0 && pending == 0 && items_seen == sent && !timed_out)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/dpg_pkg.sv
rtl/dpg_point.sv
rtl/dpg_plane.sv
rtl/dpg_grid.sv
rtl/depth_pixel_to_floor_grid_mark.sv
rtl/dpg_checker.sv
dv/dpg_checker.sv
dv/tb_depth_pixel_to_floor_grid_mark.sv
